// ----- hdl/srlm_pkg.sv -----
// Shared constants, widths and controller/datapath command types for the
// segment RMS level meter. No dependencies.
package srlm_pkg;

  localparam int BAND_COUNT   = 12;
  localparam int MAX_FRAME    = 1152;

  localparam int SAMPLE_W     = 16;
  localparam int FRAME_LEN_W  = 11;
  localparam int BAND_INDEX_W = 4;
  localparam int LEVEL_W      = 7;

  localparam int COUNT_W      = $clog2(MAX_FRAME + 1);
  localparam int BAND_W       = $clog2(BAND_COUNT + 1);
  localparam int BAND_MAX     = (MAX_FRAME + BAND_COUNT - 1) / BAND_COUNT;
  localparam int LEN_W        = $clog2(BAND_MAX + 1);

  // square of a 16-bit sample is at most 2^30
  localparam int SQ_W         = 31;
  localparam int SUM_W        = 30 + $clog2(BAND_MAX + 1);
  localparam int MEAN_W       = 31;
  localparam int ROOT_W       = 16;
  localparam int DIV_CNT_W    = $clog2(SUM_W + 1);
  localparam int SQRT_CNT_W   = $clog2(ROOT_W + 1);

  // band edge floor(b*n/BAND_COUNT) by reciprocal multiply, exact over range
  localparam int PROD_W       = $clog2(BAND_COUNT * MAX_FRAME + 1);
  localparam int RECIP_SHIFT  = PROD_W + $clog2(BAND_COUNT);
  localparam int RECIP_MUL    = (2 ** RECIP_SHIFT + BAND_COUNT - 1) / BAND_COUNT;
  localparam int RECIP_W      = $clog2(RECIP_MUL + 1);

  localparam int LEVEL_GAIN   = 130;
  localparam int GAIN_W       = 8;
  localparam int LEVEL_SHIFT  = 15;
  localparam int LEVEL_MAX    = 100;

  typedef struct packed {
    logic               take_sample;
    logic               start_frame;
    logic               acc;
    logic               edge_mul;
    logic               edge_div;
    logic               start_div;
    logic               start_sqrt;
    logic               scale;
    logic               clamp;
    logic               zero_level;
    logic               advance;
    logic [BAND_W-1:0]  band;
    logic [COUNT_W-1:0] length;
  } srlm_cmd_t;

  typedef struct packed {
    logic [COUNT_W-1:0] edge_hi;
    logic               edge_empty;
    logic               div_busy;
    logic               sqrt_busy;
    logic [LEVEL_W-1:0] level;
  } srlm_status_t;

endpackage

// ----- hdl/srlm_in_if.sv -----
// Sample input channel: valid/ready handshake with sample and frame length.
// Depends on srlm_pkg.
interface srlm_in_if import srlm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic [FRAME_LEN_W-1:0]     frame_length;

  modport source (output valid, sample, frame_length, input ready);
  modport sink (input valid, sample, frame_length, output ready);
endinterface

// ----- hdl/srlm_out_if.sv -----
// Band level output channel: valid/ready handshake with band results.
// Depends on srlm_pkg.
interface srlm_out_if import srlm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [BAND_INDEX_W-1:0] band_index;
  logic [LEVEL_W-1:0]      level_percent;
  logic                    last_band;

  modport source (output valid, band_index, level_percent, last_band, input ready);
  modport sink (input valid, band_index, level_percent, last_band, output ready);
endinterface

// ----- hdl/srlm_div.sv -----
// Restoring divider, one quotient bit per cycle: band square sum / band length.
// Depends on srlm_pkg.
module srlm_div import srlm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [LEN_W-1:0] divisor,
  output logic             busy,
  output logic [SUM_W-1:0] quotient
);

  logic [LEN_W-1:0]     rem;
  logic [LEN_W-1:0]     dvsr;
  logic [DIV_CNT_W-1:0] cnt;
  logic [LEN_W:0]       shifted;
  logic [LEN_W:0]       diff;
  logic                 fits;

  assign shifted = {rem, quotient[SUM_W-1]};
  assign fits    = shifted >= {1'b0, dvsr};
  assign diff    = shifted - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      rem      <= '0;
      dvsr     <= divisor;
      quotient <= dividend;
      cnt      <= DIV_CNT_W'(SUM_W);
      busy     <= 1'b1;
    end else if (busy) begin
      rem      <= fits ? diff[LEN_W-1:0] : shifted[LEN_W-1:0];
      quotient <= {quotient[SUM_W-2:0], fits};
      cnt      <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) busy <= 1'b0;
    end
  end

endmodule

// ----- hdl/srlm_sqrt.sv -----
// Digit-by-digit integer floor square root, one root bit per cycle.
// Depends on srlm_pkg.
module srlm_sqrt import srlm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [2*ROOT_W-1:0] radicand,
  output logic                busy,
  output logic [ROOT_W-1:0]   root
);

  logic [2*ROOT_W-1:0]   x;
  logic [ROOT_W+2:0]     rem;
  logic [SQRT_CNT_W-1:0] cnt;
  logic [ROOT_W+2:0]     rem_sh;
  logic [ROOT_W+2:0]     trial;
  logic                  fits;

  assign rem_sh = {rem[ROOT_W:0], x[2*ROOT_W-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      x    <= radicand;
      rem  <= '0;
      root <= '0;
      cnt  <= SQRT_CNT_W'(ROOT_W);
      busy <= 1'b1;
    end else if (busy) begin
      rem  <= fits ? rem_sh - trial : rem_sh;
      root <= {root[ROOT_W-2:0], fits};
      x    <= x << 2;
      cnt  <= cnt - 1'b1;
      if (cnt == SQRT_CNT_W'(1)) busy <= 1'b0;
    end
  end

endmodule

// ----- hdl/srlm_dp.sv -----
// Datapath: sample squaring, band sum, band edges, mean, root and scaling.
// Depends on srlm_pkg, srlm_div and srlm_sqrt.
module srlm_dp import srlm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  srlm_cmd_t                  cmd,
  output srlm_status_t               status
);

  logic signed [2*SAMPLE_W-1:0] sample_sq;
  logic [SQ_W-1:0]              sq;
  logic [SUM_W-1:0]             square_sum;
  logic [BAND_W-1:0]            band_next;
  logic [BAND_W+COUNT_W-1:0]    edge_mul;
  logic [PROD_W-1:0]            edge_prod;
  logic [PROD_W+RECIP_W-1:0]    recip_prod;
  logic [COUNT_W-1:0]           edge_lo;
  logic [COUNT_W-1:0]           edge_hi;
  logic [LEN_W-1:0]             band_len;
  logic [SUM_W-1:0]             quotient;
  logic                         div_busy;
  logic [ROOT_W-1:0]            root;
  logic                         sqrt_busy;
  logic [ROOT_W+GAIN_W-1:0]     level_prod;
  logic [ROOT_W+GAIN_W-1:0]     scaled;
  logic [LEVEL_W-1:0]           level;

  assign sample_sq  = sample * sample;
  assign band_next  = cmd.band + 1'b1;
  assign edge_mul   = band_next * cmd.length;
  assign recip_prod = edge_prod * RECIP_W'(RECIP_MUL);
  assign band_len   = LEN_W'(edge_hi - edge_lo);
  assign scaled     = level_prod >> LEVEL_SHIFT;

  always_ff @(posedge clk) begin
    if (cmd.take_sample) sq <= sample_sq[SQ_W-1:0];

    if (cmd.start_frame)    square_sum <= '0;
    else if (cmd.acc)       square_sum <= square_sum + SUM_W'(sq);
    else if (cmd.start_div) square_sum <= '0;

    if (cmd.edge_mul) edge_prod <= PROD_W'(edge_mul);
    if (cmd.edge_div) edge_hi <= COUNT_W'(recip_prod >> RECIP_SHIFT);

    if (cmd.start_frame)  edge_lo <= '0;
    else if (cmd.advance) edge_lo <= edge_hi;

    if (cmd.scale) level_prod <= root * GAIN_W'(LEVEL_GAIN);

    if (cmd.zero_level) begin
      level <= '0;
    end else if (cmd.clamp) begin
      level <= (scaled > (ROOT_W+GAIN_W)'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX)
                                                      : LEVEL_W'(scaled);
    end
  end

  srlm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start_div),
    .dividend (square_sum),
    .divisor  (band_len),
    .busy     (div_busy),
    .quotient (quotient)
  );

  srlm_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start_sqrt),
    .radicand ((2*ROOT_W)'(quotient[MEAN_W-1:0])),
    .busy     (sqrt_busy),
    .root     (root)
  );

  assign status.edge_hi    = edge_hi;
  assign status.edge_empty = (edge_hi == edge_lo);
  assign status.div_busy   = div_busy;
  assign status.sqrt_busy  = sqrt_busy;
  assign status.level      = level;

endmodule

// ----- hdl/srlm_ctrl.sv -----
// Controller: frame and band counters, sequencing of the datapath and the
// output register. Depends on srlm_pkg.
module srlm_ctrl import srlm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [FRAME_LEN_W-1:0]  frame_length,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [BAND_INDEX_W-1:0] band_index,
  output logic [LEVEL_W-1:0]      level_percent,
  output logic                    last_band,
  output srlm_cmd_t               cmd,
  input  srlm_status_t            status
);

  typedef enum logic [3:0] {
    S_IDLE, S_ACC, S_EDGE_MUL, S_EDGE_DIV, S_CHECK,
    S_DIV, S_SQRT, S_SCALE, S_CLAMP, S_EMIT
  } state_t;

  state_t                         state;
  logic [COUNT_W-1:0]             sample_count;
  logic [BAND_W-1:0]              band_number;
  logic [COUNT_W-1:0]             latched_length;
  logic [COUNT_W-1:0]             len_clamped;
  logic [BAND_W+BAND_INDEX_W-1:0] band_wide;
  logic                           out_free;
  logic                           band_done;
  logic                           is_last;

  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign band_done = (status.edge_hi <= sample_count);
  assign is_last   = (band_number == BAND_W'(BAND_COUNT - 1));
  assign band_wide = {{BAND_INDEX_W{1'b0}}, band_number};

  always_comb begin
    if (frame_length == '0)                 len_clamped = COUNT_W'(1);
    else if (32'(frame_length) > MAX_FRAME) len_clamped = COUNT_W'(MAX_FRAME);
    else                                    len_clamped = COUNT_W'(frame_length);
  end

  always_comb begin
    cmd        = '0;
    cmd.band   = band_number;
    cmd.length = latched_length;
    case (state)
      S_IDLE: begin
        cmd.take_sample = in_valid;
        cmd.start_frame = in_valid && (sample_count == '0);
      end
      S_ACC:      cmd.acc = 1'b1;
      S_EDGE_MUL: cmd.edge_mul = 1'b1;
      S_EDGE_DIV: cmd.edge_div = 1'b1;
      S_CHECK: begin
        cmd.zero_level = band_done && status.edge_empty;
        cmd.start_div  = band_done && !status.edge_empty;
      end
      S_DIV:   cmd.start_sqrt = !status.div_busy;
      S_SCALE: cmd.scale = 1'b1;
      S_CLAMP: cmd.clamp = 1'b1;
      S_EMIT:  cmd.advance = out_free;
      default: cmd.band = band_number;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      sample_count   <= '0;
      band_number    <= '0;
      latched_length <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (state == S_EMIT && out_free) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (sample_count == '0) begin
              latched_length <= len_clamped;
              band_number    <= '0;
            end
            sample_count <= sample_count + 1'b1;
            state        <= S_ACC;
          end
        end
        S_ACC:      state <= S_EDGE_MUL;
        S_EDGE_MUL: state <= S_EDGE_DIV;
        S_EDGE_DIV: state <= S_CHECK;
        S_CHECK: begin
          if (!band_done)             state <= S_IDLE;
          else if (status.edge_empty) state <= S_EMIT;
          else                        state <= S_DIV;
        end
        S_DIV:   if (!status.div_busy) state <= S_SQRT;
        S_SQRT:  if (!status.sqrt_busy) state <= S_SCALE;
        S_SCALE: state <= S_CLAMP;
        S_CLAMP: state <= S_EMIT;
        S_EMIT: begin
          if (out_free) begin
            band_index    <= band_wide[BAND_INDEX_W-1:0];
            level_percent <= status.level;
            last_band     <= is_last;
            if (is_last) begin
              sample_count <= '0;
              band_number  <= '0;
              state        <= S_IDLE;
            end else begin
              band_number <= band_number + 1'b1;
              state       <= S_EDGE_MUL;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/segment_rms_level_meter_top.sv -----
// Top level of the segment RMS level meter: channel interfaces, controller
// and datapath. Depends on srlm_pkg, srlm_in_if, srlm_out_if, srlm_ctrl, srlm_dp.
//
// Usage: mono samples enter on the samples channel; frame_length is read on
// the first sample of each frame (0 taken as 1, above MAX_FRAME saturated).
// Each frame is split into BAND_COUNT bands; one transfer per band leaves on
// the levels channel with band_index, level_percent (0..100) and last_band
// set on the frame's final band. Empty bands (short frames) report 0.
// Sequence: a sample that closes no band passes accept, add, edge multiply,
// edge divide and compare. Each closed band then runs the bit-serial
// divider and square root, scale, clamp and emit; an empty band goes from
// compare straight to emit. A new sample is taken only once the previous
// one and every band that it closes have been handed to the output register.
// A band result waits in an output register, so the next sample is accepted
// while it is stalled; the block holds before a further band result until
// the pending one is taken. Reset (synchronous, rst high) returns to the
// start of a frame with the output channel empty.
module segment_rms_level_meter_top import srlm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  srlm_in_if.sink     samples,
  srlm_out_if.source  levels
);

  srlm_cmd_t    cmd;
  srlm_status_t status;

  srlm_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (samples.valid),
    .in_ready      (samples.ready),
    .frame_length  (samples.frame_length),
    .out_valid     (levels.valid),
    .out_ready     (levels.ready),
    .band_index    (levels.band_index),
    .level_percent (levels.level_percent),
    .last_band     (levels.last_band),
    .cmd           (cmd),
    .status        (status)
  );

  srlm_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .sample (samples.sample),
    .cmd    (cmd),
    .status (status)
  );

endmodule
